// File: hdl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// shared types, constants and helpers of the plane / triangle classifier
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int CoordW       = 32;
  localparam int NrmW         = 18;
  localparam int EpsW         = 16;
  localparam int NrmFrac      = 16;
  localparam int DiffW        = CoordW + 1;
  localparam int ProdW        = DiffW + NrmW;
  localparam int SumW         = ProdW + 2;
  localparam int DotW         = SumW - NrmFrac;
  localparam int FracW        = NrmFrac + 1;
  localparam int QuotBits     = NrmFrac;
  localparam int BitsPerStage = 4;
  localparam int DivStages    = QuotBits / BitsPerStage;
  localparam int RoundHalf    = 2 ** (NrmFrac - 1);
  localparam int NumRegs      = 8;
  localparam int AddrW        = 5;
  localparam int ApbW         = 32;
  localparam int InDataW      = 9 * CoordW;
  localparam int OutDataW     = 216;

  typedef enum logic {
    OP_CLASSIFY  = 1'b0,
    OP_INTERSECT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    SIDE_ON    = 2'd0,
    SIDE_FRONT = 2'd1,
    SIDE_BACK  = 2'd2,
    SIDE_SPAN  = 2'd3
  } side_e;

  typedef enum logic [2:0] {
    REG_PT_X    = 3'd0,
    REG_PT_Y    = 3'd1,
    REG_PT_Z    = 3'd2,
    REG_NRM_X   = 3'd3,
    REG_NRM_Y   = 3'd4,
    REG_NRM_Z   = 3'd5,
    REG_ON_EPS  = 3'd6,
    REG_PAR_EPS = 3'd7
  } reg_e;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [NrmW-1:0]   nrm_t;
  typedef logic        [EpsW-1:0]   eps_t;
  typedef logic signed [DiffW-1:0]  diff_t;
  typedef logic signed [ProdW-1:0]  prod_t;
  typedef logic signed [DotW-1:0]   dot_t;
  typedef logic        [DotW-1:0]   mag_t;
  typedef logic        [FracW-1:0]  frac_t;
  typedef logic        [QuotBits-1:0] quot_t;

  localparam frac_t FracOne = frac_t'(2 ** NrmFrac);

  typedef struct packed {
    coord_t [2:0] pt;
    nrm_t   [2:0] nrm;
    eps_t         on_eps;
    eps_t         par_eps;
  } cfg_t;

  typedef struct packed {
    op_e          op;
    coord_t [2:0] va;
    coord_t [2:0] vb;
    coord_t [2:0] vc;
  } item_t;

  typedef struct packed {
    op_e          op;
    dot_t   [2:0] dot;
    coord_t [2:0] va;
    diff_t  [2:0] dir;
  } dots_t;

  typedef struct packed {
    side_e        side;
    coord_t [2:0] vdist;
    logic         reject;
    logic         equal;
    mag_t         rem;
    mag_t         al;
    quot_t        quo;
    coord_t [2:0] va;
    diff_t  [2:0] dir;
  } mid_t;

  typedef struct packed {
    side_e        side;
    coord_t [2:0] vdist;
    logic         hit;
    frac_t        frac;
    coord_t [2:0] pt;
  } res_t;

  // clamp a wide signed value into the coordinate range
  function automatic coord_t sat_coord(input dot_t x);
    dot_t hi_lim;
    dot_t lo_lim;
    hi_lim = {{(DotW - CoordW + 1){1'b0}}, {(CoordW - 1){1'b1}}};
    lo_lim = {{(DotW - CoordW + 1){1'b1}}, {(CoordW - 1){1'b0}}};
    if (x > hi_lim) begin
      return hi_lim[CoordW-1:0];
    end else if (x < lo_lim) begin
      return lo_lim[CoordW-1:0];
    end
    return x[CoordW-1:0];
  endfunction

  function automatic mag_t abs_dot(input dot_t x);
    dot_t n;
    n = -x;
    return x[DotW-1] ? mag_t'(n) : mag_t'(x);
  endfunction

endpackage

// File: hdl/ptc_dot.sv
// ----------------------------------------------------------------------------
// ptc_dot
// three stage dot product against the plane normal: differences, products,
// rounded sum
// ----------------------------------------------------------------------------
module ptc_dot (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  ptc_pkg::item_t item_i,
  input  ptc_pkg::cfg_t  cfg_i,
  output logic          valid_o,
  output ptc_pkg::dots_t dots_o
);
  import ptc_pkg::*;

  typedef struct packed {
    op_e                op;
    diff_t  [2:0][2:0]  diff;
    coord_t [2:0]       va;
  } s1_t;

  typedef struct packed {
    op_e                op;
    prod_t  [2:0][2:0]  prod;
    coord_t [2:0]       va;
    diff_t  [2:0]       dir;
  } s2_t;

  logic [2:0] v_q;
  s1_t        s1_d, s1_q;
  s2_t        s2_d, s2_q;
  dots_t      s3_d, s3_q;

  // stage 1: coordinate differences (vertex b gives the direction for segments)
  always_comb begin
    s1_d.op = item_i.op;
    s1_d.va = item_i.va;
    for (int i = 0; i < 3; i++) begin
      s1_d.diff[0][i] = diff_t'($signed(cfg_i.pt[i])) - diff_t'($signed(item_i.va[i]));
      if (item_i.op == OP_INTERSECT) begin
        s1_d.diff[1][i] = diff_t'($signed(item_i.vb[i])) - diff_t'($signed(item_i.va[i]));
      end else begin
        s1_d.diff[1][i] = diff_t'($signed(cfg_i.pt[i])) - diff_t'($signed(item_i.vb[i]));
      end
      s1_d.diff[2][i] = diff_t'($signed(cfg_i.pt[i])) - diff_t'($signed(item_i.vc[i]));
    end
  end

  // stage 2: nine products with the normal
  always_comb begin
    s2_d.op  = s1_q.op;
    s2_d.va  = s1_q.va;
    s2_d.dir = s1_q.diff[1];
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        s2_d.prod[k][i] = $signed(s1_q.diff[k][i]) * $signed(cfg_i.nrm[i]);
      end
    end
  end

  // stage 3: sum and round back to the coordinate format
  always_comb begin
    logic signed [SumW-1:0] sum;
    s3_d.op  = s2_q.op;
    s3_d.va  = s2_q.va;
    s3_d.dir = s2_q.dir;
    for (int k = 0; k < 3; k++) begin
      sum = SumW'($signed(s2_q.prod[k][0])) + SumW'($signed(s2_q.prod[k][1]))
          + SumW'($signed(s2_q.prod[k][2])) + SumW'(RoundHalf);
      s3_d.dot[k] = dot_t'(sum >>> NrmFrac);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[1:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
    end
  end

  assign valid_o = v_q[2];
  assign dots_o  = s3_q;

endmodule

// File: hdl/ptc_classify.sv
// ----------------------------------------------------------------------------
// ptc_classify
// one stage: on-plane test and side of a triangle, parallel and range checks
// of a segment
// ----------------------------------------------------------------------------
module ptc_classify (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  ptc_pkg::dots_t dots_i,
  input  ptc_pkg::cfg_t  cfg_i,
  output logic           valid_o,
  output ptc_pkg::mid_t  mid_o
);
  import ptc_pkg::*;

  logic v_q;
  mid_t mid_d, mid_q;

  always_comb begin
    mag_t [2:0] ad;
    logic [2:0] on, bk, fr;
    dot_t       len, sdist;
    mag_t       al, adist;
    logic       opposite;

    for (int k = 0; k < 3; k++) begin
      ad[k] = abs_dot(dots_i.dot[k]);
      on[k] = ad[k] < mag_t'(cfg_i.on_eps);
      bk[k] = on[k] | (dots_i.dot[k] > 0);
      fr[k] = on[k] | ~(dots_i.dot[k] > 0);
    end

    len      = dots_i.dot[1];
    sdist    = dots_i.dot[0];
    al       = ad[1];
    adist    = ad[0];
    opposite = (sdist != 0) && (sdist[DotW-1] != len[DotW-1]);

    mid_d.va    = dots_i.va;
    mid_d.dir   = dots_i.dir;
    mid_d.rem   = adist;
    mid_d.al    = al;
    mid_d.quo   = '0;
    mid_d.equal = adist == al;

    if (dots_i.op == OP_CLASSIFY) begin
      mid_d.reject = 1'b1;
      for (int k = 0; k < 3; k++) begin
        mid_d.vdist[k] = on[k] ? '0 : sat_coord(dots_i.dot[k]);
      end
      if (&on) begin
        mid_d.side = SIDE_ON;
      end else if (&bk) begin
        mid_d.side = SIDE_BACK;
      end else if (&fr) begin
        mid_d.side = SIDE_FRONT;
      end else begin
        mid_d.side = SIDE_SPAN;
      end
    end else begin
      mid_d.side     = SIDE_ON;
      mid_d.vdist[0] = sat_coord(sdist);
      mid_d.vdist[1] = '0;
      mid_d.vdist[2] = '0;
      mid_d.reject   = (len == 0) || (al < mag_t'(cfg_i.par_eps)) || opposite
                     || (adist > al);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mid_q <= mid_d;
    end
  end

  assign valid_o = v_q;
  assign mid_o   = mid_q;

endmodule

// File: hdl/ptc_div.sv
// ----------------------------------------------------------------------------
// ptc_div
// pipelined restoring divider for the hit fraction, a few quotient bits per
// stage
// ----------------------------------------------------------------------------
module ptc_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  ptc_pkg::mid_t mid_i,
  output logic          valid_o,
  output ptc_pkg::mid_t mid_o
);
  import ptc_pkg::*;

  logic [DivStages-1:0] v_q;
  mid_t                 stg_d [DivStages];
  mid_t                 stg_q [DivStages];

  function automatic mid_t div_steps(input mid_t m);
    mid_t          r;
    logic [DotW:0] t;
    r = m;
    for (int b = 0; b < BitsPerStage; b++) begin
      t     = {r.rem, 1'b0};
      r.quo = {r.quo[QuotBits-2:0], 1'b0};
      if (t >= {1'b0, r.al}) begin
        t        = t - {1'b0, r.al};
        r.quo[0] = 1'b1;
      end
      r.rem = t[DotW-1:0];
    end
    return r;
  endfunction

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    if (s == 0) begin : g_first
      assign stg_d[s] = div_steps(mid_i);
    end else begin : g_next
      assign stg_d[s] = div_steps(stg_q[s-1]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DivStages-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < DivStages; s++) begin
        stg_q[s] <= stg_d[s];
      end
    end
  end

  assign valid_o = v_q[DivStages-1];
  assign mid_o   = stg_q[DivStages-1];

endmodule

// File: hdl/ptc_hit.sv
// ----------------------------------------------------------------------------
// ptc_hit
// hit point: direction times fraction (registered), then round, offset by
// vertex a and saturate
// ----------------------------------------------------------------------------
module ptc_hit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  ptc_pkg::mid_t mid_i,
  output logic          valid_o,
  output ptc_pkg::res_t res_o
);
  import ptc_pkg::*;

  typedef struct packed {
    side_e        side;
    coord_t [2:0] vdist;
    logic         hit;
    frac_t        frac;
    coord_t [2:0] va;
    prod_t  [2:0] prod;
  } sa_t;

  logic v_q;
  sa_t  sa_d, sa_q;

  always_comb begin
    sa_d.side  = mid_i.side;
    sa_d.vdist = mid_i.vdist;
    sa_d.va    = mid_i.va;
    sa_d.hit   = ~mid_i.reject;
    if (mid_i.reject) begin
      sa_d.frac = '0;
    end else if (mid_i.equal) begin
      sa_d.frac = FracOne;
    end else begin
      sa_d.frac = {1'b0, mid_i.quo};
    end
    for (int i = 0; i < 3; i++) begin
      sa_d.prod[i] = $signed(mid_i.dir[i]) * $signed({1'b0, sa_d.frac});
    end
  end

  always_comb begin
    prod_t pr;
    dot_t  h;
    res_o.side  = sa_q.side;
    res_o.vdist = sa_q.vdist;
    res_o.hit   = sa_q.hit;
    res_o.frac  = sa_q.frac;
    for (int i = 0; i < 3; i++) begin
      pr = sa_q.prod[i] + ProdW'(RoundHalf);
      h  = dot_t'(pr >>> NrmFrac) + dot_t'($signed(sa_q.va[i]));
      res_o.pt[i] = sa_q.hit ? sat_coord(h) : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sa_q <= sa_d;
    end
  end

  assign valid_o = v_q;

endmodule

// File: hdl/plane_triangle_classify.sv
// ----------------------------------------------------------------------------
// plane_triangle_classify
// triangle side classification and segment intersection against a fixed plane
// ----------------------------------------------------------------------------
// Accepts one beat per clock while the result side is not stalled and returns
// one result beat for each, in order. The pipeline holds ten register stages:
// three stages of dot product (differences, 33x18 products, rounded sum), one
// stage of classification and range checks, four stages of the fraction
// divider (four quotient bits each), one stage of the 33x18 hit-point products
// and the output register. A stall on the result side holds the whole
// pipeline; s_axis_tready drops only while a result is waiting and the master
// side is not ready. Opcode 0 classifies triangle a,b,c; opcode 1 intersects
// segment a->b (vertex c ignored). The plane must be written over the APB port
// only while the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module plane_triangle_classify (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
  // vert_c_x, vert_c_y, vert_c_z (32 bits each, from bit 0 up)
  input  logic [ptc_pkg::InDataW-1:0]   s_axis_tdata,
  // opcode
  input  logic                          s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // side[1:0], dist_a, dist_b, dist_c, hit, fraction[16:0], hit_x, hit_y,
  // hit_z, zero fill (from bit 0 up)
  output logic [ptc_pkg::OutDataW-1:0]  m_axis_tdata,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptc_pkg::AddrW-1:0]     paddr,
  input  logic [ptc_pkg::ApbW-1:0]      pwdata,
  output logic [ptc_pkg::ApbW-1:0]      prdata,
  output logic                          pready
);
  import ptc_pkg::*;

  cfg_t  cfg_q;
  reg_e  reg_sel;
  logic  cfg_wr;

  logic  en;
  item_t item;
  logic  dot_valid, cls_valid, div_valid, hit_valid;
  dots_t dots;
  mid_t  cls_mid, div_mid;
  res_t  res;

  logic  out_valid_q;
  res_t  out_q;

  // ---------------- configuration registers ----------------
  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pt      <= '0;
      cfg_q.nrm[0]  <= '0;
      cfg_q.nrm[1]  <= '0;
      cfg_q.nrm[2]  <= nrm_t'(2 ** NrmFrac);
      cfg_q.on_eps  <= eps_t'(66);
      cfg_q.par_eps <= eps_t'(7);
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_PT_X:    cfg_q.pt[0]   <= pwdata[CoordW-1:0];
        REG_PT_Y:    cfg_q.pt[1]   <= pwdata[CoordW-1:0];
        REG_PT_Z:    cfg_q.pt[2]   <= pwdata[CoordW-1:0];
        REG_NRM_X:   cfg_q.nrm[0]  <= pwdata[NrmW-1:0];
        REG_NRM_Y:   cfg_q.nrm[1]  <= pwdata[NrmW-1:0];
        REG_NRM_Z:   cfg_q.nrm[2]  <= pwdata[NrmW-1:0];
        REG_ON_EPS:  cfg_q.on_eps  <= pwdata[EpsW-1:0];
        REG_PAR_EPS: cfg_q.par_eps <= pwdata[EpsW-1:0];
        default:     cfg_q.pt[0]   <= cfg_q.pt[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_PT_X:    prdata = ApbW'($unsigned(cfg_q.pt[0]));
      REG_PT_Y:    prdata = ApbW'($unsigned(cfg_q.pt[1]));
      REG_PT_Z:    prdata = ApbW'($unsigned(cfg_q.pt[2]));
      REG_NRM_X:   prdata = ApbW'($unsigned(cfg_q.nrm[0]));
      REG_NRM_Y:   prdata = ApbW'($unsigned(cfg_q.nrm[1]));
      REG_NRM_Z:   prdata = ApbW'($unsigned(cfg_q.nrm[2]));
      REG_ON_EPS:  prdata = ApbW'(cfg_q.on_eps);
      REG_PAR_EPS: prdata = ApbW'(cfg_q.par_eps);
      default:     prdata = '0;
    endcase
  end

  // ---------------- input unpacking ----------------
  always_comb begin
    item.op = op_e'(s_axis_tuser);
    for (int i = 0; i < 3; i++) begin
      item.va[i] = s_axis_tdata[i * CoordW +: CoordW];
      item.vb[i] = s_axis_tdata[(3 + i) * CoordW +: CoordW];
      item.vc[i] = s_axis_tdata[(6 + i) * CoordW +: CoordW];
    end
  end

  // the whole pipeline advances together unless a result is held
  assign en            = ~out_valid_q | m_axis_tready;
  assign s_axis_tready = en;

  ptc_dot u_dot (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_axis_tvalid),
    .item_i  (item),
    .cfg_i   (cfg_q),
    .valid_o (dot_valid),
    .dots_o  (dots)
  );

  ptc_classify u_classify (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dot_valid),
    .dots_i  (dots),
    .cfg_i   (cfg_q),
    .valid_o (cls_valid),
    .mid_o   (cls_mid)
  );

  ptc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cls_valid),
    .mid_i   (cls_mid),
    .valid_o (div_valid),
    .mid_o   (div_mid)
  );

  ptc_hit u_hit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (div_valid),
    .mid_i   (div_mid),
    .valid_o (hit_valid),
    .res_o   (res)
  );

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= hit_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {
    {(OutDataW - 212){1'b0}},
    out_q.pt[2], out_q.pt[1], out_q.pt[0],
    out_q.frac, out_q.hit,
    out_q.vdist[2], out_q.vdist[1], out_q.vdist[0],
    out_q.side
  };

endmodule

// File: sim/tb_plane_triangle_classify.sv
// ----------------------------------------------------------------------------
// tb_plane_triangle_classify
// self-checking bench for the plane / triangle classifier
// ----------------------------------------------------------------------------
// Writes plane settings over APB, streams triangle classify and segment
// intersect beats with random idling on both sides, and compares every result
// beat field by field against a bit-accurate predictor kept in this bench.
// ----------------------------------------------------------------------------
module tb_plane_triangle_classify;
  timeunit 1ns;
  timeprecision 1ps;
  import ptc_pkg::*;

  // one pending input beat and one expected result
  typedef struct {
    op_e             op;
    logic [31:0]     v[9];
  } beat_in_t;

  typedef struct {
    logic [1:0]      side;
    logic [31:0]     vdist[3];
    logic            hit;
    logic [16:0]     frac;
    logic [31:0]     pt[3];
  } beat_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [ApbW-1:0] pwdata = '0;
  logic [ApbW-1:0] prdata;
  logic pready;

  // acceptance seen at the rising edge, used by the driver at the next falling edge
  logic s_axis_tready_q = 1'b0;

  plane_triangle_classify uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // plane settings as the predictor sees them
  longint pt_q[3];
  longint nrm_q[3];
  longint on_eps_q;
  longint par_eps_q;

  beat_in_t  pending_beats[$];
  beat_res_t expected_res[$];
  int        mismatches = 0;
  int        unexpected = 0;
  int        checked = 0;
  int        hits_seen = 0;
  bit        quiet = 1'b0;      // long stretch with no idling
  bit        feed_on = 1'b0;

  function automatic longint floor_shr16(longint x);
    return x >>> 16;
  endfunction

  function automatic logic [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'h7fffffff;
    if (x < -64'sd2147483648) return 32'h80000000;
    return x[31:0];
  endfunction

  // rounded dot(p - q, normal) back in coordinate format
  function automatic longint plane_dot(longint p[3], longint q[3]);
    longint hi, lo, d, dh;
    hi = 0;
    lo = 0;
    for (int i = 0; i < 3; i++) begin
      d = p[i] - q[i];
      dh = floor_shr16(d);
      hi += dh * nrm_q[i];
      lo += (d - dh * 65536) * nrm_q[i];
    end
    return hi + floor_shr16(lo + 32768);
  endfunction

  function automatic beat_res_t predict_result(beat_in_t b);
    beat_res_t r;
    longint va[3], vb[3], vc[3], vk[3], d, ad, len, al;
    longint rem, fr, dir, dh;
    int on_n, fr_n, bk_n;
    r.side = SIDE_ON;
    r.hit = 1'b0;
    r.frac = '0;
    for (int i = 0; i < 3; i++) begin
      r.vdist[i] = '0;
      r.pt[i] = '0;
      va[i] = longint'(signed'(b.v[i]));
      vb[i] = longint'(signed'(b.v[3+i]));
      vc[i] = longint'(signed'(b.v[6+i]));
    end
    if (b.op == OP_CLASSIFY) begin
      on_n = 0; fr_n = 0; bk_n = 0;
      for (int k = 0; k < 3; k++) begin
        for (int i = 0; i < 3; i++) vk[i] = k == 0 ? va[i] : (k == 1 ? vb[i] : vc[i]);
        d = plane_dot(pt_q, vk);
        ad = d < 0 ? -d : d;
        if (ad < on_eps_q) begin
          d = 0; on_n++; fr_n++; bk_n++;
        end else if (d > 0) begin
          bk_n++;
        end else begin
          fr_n++;
        end
        r.vdist[k] = clamp32(d);
      end
      r.side = on_n == 3 ? SIDE_ON : bk_n == 3 ? SIDE_BACK :
               fr_n == 3 ? SIDE_FRONT : SIDE_SPAN;
      return r;
    end
    len = plane_dot(vb, va);
    d = plane_dot(pt_q, va);
    al = len < 0 ? -len : len;
    ad = d < 0 ? -d : d;
    r.vdist[0] = clamp32(d);
    if (len == 0 || al < par_eps_q) return r;
    if (d != 0 && ((d < 0) != (len < 0))) return r;
    if (ad > al) return r;
    if (ad == al) begin
      fr = 65536;
    end else begin
      rem = ad;
      fr = 0;
      for (int i = 0; i < 16; i++) begin
        rem = rem << 1;
        fr = fr << 1;
        if (rem >= al) begin
          rem -= al;
          fr |= 1;
        end
      end
    end
    r.hit = 1'b1;
    r.frac = fr[16:0];
    for (int i = 0; i < 3; i++) begin
      dir = vb[i] - va[i];
      dh = floor_shr16(dir);
      r.pt[i] = clamp32(va[i] + dh * fr + floor_shr16((dir - dh * 65536) * fr + 32768));
    end
    return r;
  endfunction

  // input driver: changes on the falling edge, beat taken at the rising edge
  always @(negedge clk_i) begin
    beat_in_t b;
    if (s_axis_tvalid && s_axis_tready_q) begin
      // previous beat was accepted at the last rising edge
    end
    if (!s_axis_tvalid || s_axis_tready_q) begin
      if (feed_on && pending_beats.size() > 0 && (quiet || $urandom_range(99) >= 17)) begin
        b = pending_beats.pop_front();
        expected_res.push_back(predict_result(b));
        s_axis_tuser <= b.op;
        for (int i = 0; i < 9; i++) s_axis_tdata[32*i +: 32] <= b.v[i];
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= quiet || $urandom_range(99) >= 17;
  end

  always @(posedge clk_i) s_axis_tready_q <= s_axis_tready && s_axis_tvalid;

  // result monitor
  always @(posedge clk_i) begin
    beat_res_t e;
    beat_res_t a;
    bit bad;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      a.side = m_axis_tdata[1:0];
      for (int i = 0; i < 3; i++) a.vdist[i] = m_axis_tdata[2 + 32*i +: 32];
      a.hit = m_axis_tdata[98];
      a.frac = m_axis_tdata[99 +: 17];
      for (int i = 0; i < 3; i++) a.pt[i] = m_axis_tdata[116 + 32*i +: 32];
      if (expected_res.size() == 0) begin
        unexpected++;
        mismatches++;
        if (mismatches <= 10) $display("result beat with nothing expected");
      end else begin
        e = expected_res.pop_front();
        checked++;
        if (a.hit) hits_seen++;
        bad = a.side != e.side || a.hit != e.hit || a.frac != e.frac;
        for (int i = 0; i < 3; i++) bad |= a.vdist[i] != e.vdist[i] || a.pt[i] != e.pt[i];
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch beat %0d: exp side %0d dist %h %h %h hit %0d frac %h pt %h %h %h",
                     checked, e.side, e.vdist[0], e.vdist[1], e.vdist[2], e.hit, e.frac,
                     e.pt[0], e.pt[1], e.pt[2]);
            $display("                 got side %0d dist %h %h %h hit %0d frac %h pt %h %h %h",
                     a.side, a.vdist[0], a.vdist[1], a.vdist[2], a.hit, a.frac,
                     a.pt[0], a.pt[1], a.pt[2]);
          end
        end
      end
    end
  end

  // APB write: setup then access, register written at the access edge
  task automatic write_reg(reg_e idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= AddrW'(4 * idx);
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_PT_X, REG_PT_Y, REG_PT_Z: pt_q[idx] = longint'(signed'(val));
      REG_NRM_X, REG_NRM_Y, REG_NRM_Z:
        nrm_q[idx - REG_NRM_X] = longint'(signed'(val[17:0]));
      REG_ON_EPS: on_eps_q = val[15:0];
      default: par_eps_q = val[15:0];
    endcase
  endtask

  task automatic set_plane(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                           logic [17:0] nx, logic [17:0] ny, logic [17:0] nz,
                           logic [15:0] oe, logic [15:0] pe);
    write_reg(REG_PT_X, px);
    write_reg(REG_PT_Y, py);
    write_reg(REG_PT_Z, pz);
    write_reg(REG_NRM_X, 32'(nx));
    write_reg(REG_NRM_Y, 32'(ny));
    write_reg(REG_NRM_Z, 32'(nz));
    write_reg(REG_ON_EPS, 32'(oe));
    write_reg(REG_PAR_EPS, 32'(pe));
  endtask

  // wait until the pipeline has drained
  task automatic drain();
    while (pending_beats.size() > 0 || expected_res.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // coordinate picker: mostly small, sometimes extreme or raw
  function automatic logic [31:0] pick_coord();
    case ($urandom_range(9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2, 3: return $urandom();
      default: return 32'($signed($urandom_range(0, 2 ** 22)) - 2 ** 21);
    endcase
  endfunction

  task automatic queue_random(int n);
    beat_in_t b;
    for (int k = 0; k < n; k++) begin
      b.op = op_e'($urandom_range(1));
      for (int i = 0; i < 9; i++) b.v[i] = pick_coord();
      // segments straddling the plane z = pz so that hits are common
      if (b.op == OP_INTERSECT && $urandom_range(3) != 0) begin
        b.v[2] = 32'(pt_q[2] + $signed($urandom_range(0, 2 ** 20)) - 2 ** 19);
        b.v[5] = 32'(pt_q[2] - ($signed(b.v[2]) - pt_q[2]) * $urandom_range(1, 3)
                     + $urandom_range(0, 3));
      end
      pending_beats.push_back(b);
    end
  endtask

  task automatic queue_one(op_e op, logic [31:0] a0, logic [31:0] a1, logic [31:0] a2,
                           logic [31:0] b0, logic [31:0] b1, logic [31:0] b2,
                           logic [31:0] c0, logic [31:0] c1, logic [31:0] c2);
    beat_in_t b;
    b.op = op;
    b.v = '{a0, a1, a2, b0, b1, b2, c0, c1, c2};
    pending_beats.push_back(b);
  endtask

  initial begin
    pt_q = '{0, 0, 0};
    nrm_q = '{0, 0, 65536};
    on_eps_q = 66;
    par_eps_q = 7;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    feed_on = 1'b1;

    // directed: reset plane z = 0, normal +z
    queue_one(OP_CLASSIFY, 0, 0, 0, 0, 0, 10, 0, 0, -10);              // on-plane
    queue_one(OP_CLASSIFY, 0, 0, 32'hfff00000, 0, 0, -5000, 1, 2, -100); // back
    queue_one(OP_CLASSIFY, 0, 0, 100000, 0, 0, 70, 0, 0, 5000);        // front
    queue_one(OP_CLASSIFY, 0, 0, -100000, 0, 0, 100000, 0, 0, 0);      // spanning
    queue_one(OP_CLASSIFY, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
              32'h80000000, 32'h7fffffff, 32'h80000000, '1, '1, '1);
    queue_one(OP_INTERSECT, 0, 0, -65536, 0, 0, 65536, '1, '1, '1);    // mid hit
    queue_one(OP_INTERSECT, 5, 6, 0, 100, 200, 65536, 0, 0, 0);        // zero distance
    queue_one(OP_INTERSECT, 0, 0, -65536, 0, 0, 0, 0, 0, 0);           // fraction one
    queue_one(OP_INTERSECT, 0, 0, 65536, 0, 0, 65539, 0, 0, 0);        // parallel
    queue_one(OP_INTERSECT, 0, 0, 65536, 0, 0, 65536, 0, 0, 0);        // zero length
    queue_one(OP_INTERSECT, 0, 0, 65536, 0, 0, 131072, 0, 0, 0);       // out of segment
    queue_one(OP_INTERSECT, 0, 0, -65536, 0, 0, -32768, 0, 0, 0);      // too short
    queue_one(OP_INTERSECT, 32'h80000000, 32'h80000000, 32'h80000000,
              32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0, 0);
    drain();

    // extreme plane: corner point, normals of +1, -1 and the largest positive value, max tolerances
    set_plane(32'h7fffffff, 32'h80000000, 32'h7fffffff,
              18'h10000, 18'h30000, 18'h1ffff, 16'hffff, 16'hffff);
    queue_one(OP_CLASSIFY, 32'h80000000, 32'h7fffffff, 32'h80000000,
              0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
    queue_one(OP_INTERSECT, 32'h80000000, 32'h7fffffff, 32'h80000000,
              32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 0);
    queue_random(60);
    drain();

    // zero tolerances, tilted normal, with a stretch of no idling
    set_plane(32'h00012345, 32'hfffe0000, 32'h00030000,
              18'h0b505, 18'h00000, 18'h0b505, 16'h0000, 16'h0000);
    quiet = 1'b1;
    queue_random(250);
    drain();
    quiet = 1'b0;

    // several random plane settings
    for (int ph = 0; ph < 4; ph++) begin
      set_plane(32'($signed($urandom_range(0, 2 ** 22)) - 2 ** 21),
                32'($signed($urandom_range(0, 2 ** 22)) - 2 ** 21),
                32'($signed($urandom_range(0, 2 ** 22)) - 2 ** 21),
                18'($urandom_range(0, 2 ** 17) - 2 ** 16) & 18'h3ffff,
                18'($urandom_range(0, 2 ** 17) - 2 ** 16) & 18'h3ffff,
                ph[0] ? 18'h10000 : 18'h30000,
                16'($urandom_range(0, 2000)), 16'($urandom_range(0, 200)));
      queue_random(190);
      drain();
    end

    $display("checked %0d result beats, %0d of them segment hits, over seven plane settings",
             checked, hits_seen);
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d bad beats, %0d unexpected", mismatches, unexpected);
      $display("== FAIL ==");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end

endmodule
